FILE: rtl/core/vrpe_pkg.sv
// Shared types, constants and helper functions for the voxel ray pick/edit unit.
// Used by vrpe_ray and voxel_ray_pick_edit_unit. No dependencies.
package vrpe_pkg;

    // Grid geometry and fixed-point formats.
    localparam int unsigned GRID_X     = 32;
    localparam int unsigned GRID_Y     = 64;
    localparam int unsigned GRID_Z     = 32;
    localparam int unsigned FRAC_BITS  = 12;
    localparam int unsigned DIR_FRAC   = 14;
    localparam int unsigned NUM_AXES   = 3;
    localparam int unsigned GRID_DIM [NUM_AXES] = '{GRID_X, GRID_Y, GRID_Z};

    localparam int unsigned X_W        = $clog2(GRID_X);
    localparam int unsigned Y_W        = $clog2(GRID_Y);
    localparam int unsigned Z_W        = $clog2(GRID_Z);
    localparam int unsigned CELL_COUNT = GRID_X * GRID_Y * GRID_Z;
    localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);

    // Field and register widths.
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned POS_W      = 21;
    localparam int unsigned DIR_W      = 16;
    localparam int unsigned ACTION_W   = 2;
    localparam int unsigned STEP_W     = 12;
    localparam int unsigned START_W    = 16;
    localparam int unsigned STEPS_W    = 10;
    localparam int unsigned POFF_W     = 12;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    // Datapath widths. The distance never exceeds 2^(STEPS_W+STEP_W+1).
    localparam int unsigned MUL_B_W    = START_W + 1;
    localparam int unsigned PROD_W     = DIR_W + MUL_B_W;
    localparam int unsigned ACC_W      = DIR_W + STEPS_W + STEP_W + 2;
    localparam int unsigned DSTEP_W    = DIR_W + STEP_W + 1;
    localparam int unsigned PO_W       = DIR_W + POFF_W + 1 - DIR_FRAC;
    localparam int unsigned PT_W       = ACC_W - DIR_FRAC + 1;
    localparam int unsigned CELLC_W    = PT_W - FRAC_BITS;
    localparam int unsigned PP_W       = PT_W + 1;
    localparam int unsigned PCELL_W    = PP_W - FRAC_BITS;

    // Register reset values.
    localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(205);
    localparam logic [START_W-1:0] START_RESET = START_W'(410);
    localparam logic [STEPS_W-1:0] STEPS_RESET = STEPS_W'(118);
    localparam logic [POFF_W-1:0]  POFF_RESET  = POFF_W'(410);

    localparam logic [KIND_W-1:0]  KIND_AIR    = '0;
    localparam logic               OP_WRITE    = 1'b0;
    localparam int unsigned        ACT_BREAK   = 0;
    localparam int unsigned        ACT_PLACE   = 1;
    localparam logic [1:0]         AXIS_LAST   = 2'(NUM_AXES - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SIZE      = 2'd0,
        CFG_START_DISTANCE = 2'd1,
        CFG_MAX_STEPS      = 2'd2,
        CFG_PLACE_OFFSET   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MG_START,
        MG_STEP,
        MG_PLACE
    } mul_grp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_SETUP,
        ST_MARCH,
        ST_BREAK,
        ST_PREAD,
        ST_PCHECK,
        ST_DONE
    } state_t;

    // Sequencer controls into the ray datapath.
    typedef struct packed {
        logic       load;
        logic       mul_en;
        mul_grp_t   mul_grp;
        logic [1:0] mul_axis;
        logic       advance;
    } ray_ctl_t;

    // A cell position with its in-grid flag.
    typedef struct packed {
        logic           in_grid;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic [Z_W-1:0] z;
    } ray_pos_t;

    function automatic logic in_range(input logic signed [PCELL_W-1:0] c,
                                      input int unsigned lim);
        in_range = (c >= 0) && (c < $signed(PCELL_W'(lim)));
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [X_W-1:0] x,
                                                     input logic [Y_W-1:0] y,
                                                     input logic [Z_W-1:0] z);
        cell_addr = ADDR_W'((ADDR_W'(x) * ADDR_W'(GRID_Y) + ADDR_W'(y)) * ADDR_W'(GRID_Z)
                            + ADDR_W'(z));
    endfunction

endpackage

FILE: rtl/core/vrpe_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module vrpe_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/vrpe_ray.sv
// Ray datapath: one shared multiplier for the setup products, three accumulator
// lanes that step the sample point, and cell/placement index logic. Uses vrpe_pkg.
module vrpe_ray (
    input  logic                                   aclk,
    input  vrpe_pkg::ray_ctl_t                     ctl,
    input  logic signed [vrpe_pkg::POS_W-1:0]      origin_x,
    input  logic signed [vrpe_pkg::POS_W-1:0]      origin_y,
    input  logic signed [vrpe_pkg::POS_W-1:0]      origin_z,
    input  logic signed [vrpe_pkg::DIR_W-1:0]      dir_x,
    input  logic signed [vrpe_pkg::DIR_W-1:0]      dir_y,
    input  logic signed [vrpe_pkg::DIR_W-1:0]      dir_z,
    input  logic        [vrpe_pkg::START_W-1:0]    start_distance,
    input  logic        [vrpe_pkg::STEP_W-1:0]     step_size,
    input  logic        [vrpe_pkg::POFF_W-1:0]     place_offset,
    output vrpe_pkg::ray_pos_t                     cur,
    output vrpe_pkg::ray_pos_t                     s1,
    output vrpe_pkg::ray_pos_t                     place
);
    import vrpe_pkg::*;

    logic signed [POS_W-1:0]   org_reg   [NUM_AXES];
    logic signed [DIR_W-1:0]   dir_reg   [NUM_AXES];
    logic signed [ACC_W-1:0]   acc_reg   [NUM_AXES];
    logic signed [DSTEP_W-1:0] dstep_reg [NUM_AXES];
    logic signed [PO_W-1:0]    po_reg    [NUM_AXES];
    logic signed [PT_W-1:0]    s1_pt_reg [NUM_AXES];
    ray_pos_t                  s1_reg;

    logic signed [DIR_W-1:0]   mul_a;
    logic        [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    logic signed [PT_W-1:0]    pt    [NUM_AXES];
    logic signed [CELLC_W-1:0] cellc [NUM_AXES];
    logic signed [PP_W-1:0]    pp    [NUM_AXES];
    logic signed [PCELL_W-1:0] pcell [NUM_AXES];
    logic                      cur_in   [NUM_AXES];
    logic                      place_in [NUM_AXES];

    // Shared multiplier: direction component times one of the distances.
    always_comb begin
        case (ctl.mul_axis)
            2'd0:    mul_a = dir_reg[0];
            2'd1:    mul_a = dir_reg[1];
            2'd2:    mul_a = dir_reg[2];
            default: mul_a = '0;
        endcase
        case (ctl.mul_grp)
            MG_START: mul_b = MUL_B_W'(start_distance);
            MG_STEP:  mul_b = MUL_B_W'(step_size);
            MG_PLACE: mul_b = MUL_B_W'(place_offset);
            default:  mul_b = '0;
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'($signed(mul_b));
    end

    // Sample point and cell index per axis; all shifts are floor divisions.
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            pt[i]       = PT_W'(org_reg[i]) + PT_W'(acc_reg[i] >>> DIR_FRAC);
            cellc[i]    = CELLC_W'(pt[i] >>> FRAC_BITS);
            cur_in[i]   = in_range(PCELL_W'(cellc[i]), GRID_DIM[i]);
            pp[i]       = PP_W'(s1_pt_reg[i]) + PP_W'(po_reg[i]);
            pcell[i]    = PCELL_W'(pp[i] >>> FRAC_BITS);
            place_in[i] = in_range(pcell[i], GRID_DIM[i]);
        end
    end

    assign cur.in_grid   = cur_in[0] && cur_in[1] && cur_in[2];
    assign cur.x         = cellc[0][X_W-1:0];
    assign cur.y         = cellc[1][Y_W-1:0];
    assign cur.z         = cellc[2][Z_W-1:0];
    assign place.in_grid = place_in[0] && place_in[1] && place_in[2];
    assign place.x       = pcell[0][X_W-1:0];
    assign place.y       = pcell[1][Y_W-1:0];
    assign place.z       = pcell[2][Z_W-1:0];
    assign s1            = s1_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            org_reg[0] <= origin_x;
            org_reg[1] <= origin_y;
            org_reg[2] <= origin_z;
            dir_reg[0] <= dir_x;
            dir_reg[1] <= dir_y;
            dir_reg[2] <= dir_z;
        end
        for (int i = 0; i < NUM_AXES; i++) begin
            if (ctl.mul_en && ctl.mul_axis == 2'(i)) begin
                case (ctl.mul_grp)
                    MG_START: acc_reg[i]   <= ACC_W'(mul_p);
                    MG_STEP:  dstep_reg[i] <= DSTEP_W'(mul_p);
                    MG_PLACE: po_reg[i]    <= PO_W'(mul_p >>> DIR_FRAC);
                    default:  ;
                endcase
            end
            // The product is kept exact, so each step is a plain add.
            if (ctl.advance) begin
                acc_reg[i]   <= acc_reg[i] + ACC_W'(dstep_reg[i]);
                s1_pt_reg[i] <= pt[i];
            end
        end
        if (ctl.advance) begin
            s1_reg <= cur;
        end
    end

endmodule

FILE: rtl/core/voxel_ray_pick_edit_unit.sv
// Voxel ray pick/edit unit: a write request goes from WRITE to DONE, where its result is made valid.
// A pick request runs 9 setup multiplies, one voxel read per march step through the RAM read port,
// then the break and place accesses in the BREAK, PREAD and PCHECK states.
// One request is in flight at a time; the next is taken once its result is in the output register.
// After reset a clearing pass writes air to all 65536 cells (s_ready low);
// the configuration registers reset to their defaults and may be written during the pass.
module voxel_ray_pick_edit_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [vrpe_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vrpe_pkg::CFG_W-1:0]            cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_operation,
    input  logic [vrpe_pkg::X_W-1:0]              s_cell_x,
    input  logic [vrpe_pkg::Y_W-1:0]              s_cell_y,
    input  logic [vrpe_pkg::Z_W-1:0]              s_cell_z,
    input  logic [vrpe_pkg::KIND_W-1:0]           s_cell_type,
    input  logic signed [vrpe_pkg::POS_W-1:0]     s_origin_x,
    input  logic signed [vrpe_pkg::POS_W-1:0]     s_origin_y,
    input  logic signed [vrpe_pkg::POS_W-1:0]     s_origin_z,
    input  logic signed [vrpe_pkg::DIR_W-1:0]     s_dir_x,
    input  logic signed [vrpe_pkg::DIR_W-1:0]     s_dir_y,
    input  logic signed [vrpe_pkg::DIR_W-1:0]     s_dir_z,
    input  logic [vrpe_pkg::ACTION_W-1:0]         s_action,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_hit,
    output logic [vrpe_pkg::X_W-1:0]              m_hit_x,
    output logic [vrpe_pkg::Y_W-1:0]              m_hit_y,
    output logic [vrpe_pkg::Z_W-1:0]              m_hit_z,
    output logic [vrpe_pkg::KIND_W-1:0]           m_hit_kind,
    output logic                                  m_placed,
    output logic [vrpe_pkg::X_W-1:0]              m_place_x,
    output logic [vrpe_pkg::Y_W-1:0]              m_place_y,
    output logic [vrpe_pkg::Z_W-1:0]              m_place_z
);
    import vrpe_pkg::*;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic [STEPS_W-1:0]  k_reg;
    mul_grp_t            mul_grp_reg;
    logic [1:0]          mul_axis_reg;
    logic                s1_ok_reg;

    logic [STEP_W-1:0]   step_reg;
    logic [START_W-1:0]  start_reg;
    logic [STEPS_W-1:0]  max_steps_reg;
    logic [POFF_W-1:0]   poff_reg;

    logic [X_W-1:0]      wr_x_reg;
    logic [Y_W-1:0]      wr_y_reg;
    logic [Z_W-1:0]      wr_z_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [ACTION_W-1:0] action_reg;

    logic                res_hit_reg;
    ray_pos_t            res_hit_pos_reg;
    logic [KIND_W-1:0]   res_kind_reg;
    logic                res_placed_reg;
    ray_pos_t            res_place_pos_reg;

    logic                m_valid_reg;
    logic                m_hit_reg;
    ray_pos_t            m_hit_pos_reg;
    logic [KIND_W-1:0]   m_kind_reg;
    logic                m_placed_reg;
    ray_pos_t            m_place_pos_reg;

    ray_ctl_t            ctl;
    ray_pos_t            cur, s1, place;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [KIND_W-1:0]   ram_wdata, rd_data;
    logic [ADDR_W-1:0]   cur_addr, s1_addr, place_addr;
    logic                issue, hit_now, place_ok, finish;

    assign cur_addr   = cell_addr(cur.x, cur.y, cur.z);
    assign s1_addr    = cell_addr(s1.x, s1.y, s1.z);
    assign place_addr = cell_addr(place.x, place.y, place.z);

    vrpe_ray u_ray (
        .aclk           (aclk),
        .ctl            (ctl),
        .origin_x       (s_origin_x),
        .origin_y       (s_origin_y),
        .origin_z       (s_origin_z),
        .dir_x          (s_dir_x),
        .dir_y          (s_dir_y),
        .dir_z          (s_dir_z),
        .start_distance (start_reg),
        .step_size      (step_reg),
        .place_offset   (poff_reg),
        .cur            (cur),
        .s1             (s1),
        .place          (place)
    );

    vrpe_ram #(
        .WIDTH (KIND_W),
        .DEPTH (CELL_COUNT)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        state_reg <= aresetn ? state_next : ST_CLEAR;
    end

    always_comb begin
        state_next   = state_reg;
        ram_we       = 1'b0;
        ram_waddr    = s1_addr;
        ram_wdata    = KIND_AIR;
        ram_raddr    = cur_addr;
        ctl          = '0;
        ctl.mul_grp  = mul_grp_reg;
        ctl.mul_axis = mul_axis_reg;
        issue        = 1'b0;
        hit_now      = 1'b0;
        place_ok     = 1'b0;
        finish       = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                if (clr_cnt_reg == ADDR_W'(CELL_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.load   = 1'b1;
                    state_next = (s_operation == OP_WRITE) ? ST_WRITE : ST_SETUP;
                end
            end
            ST_WRITE: begin
                ram_we     = 1'b1;
                ram_waddr  = cell_addr(wr_x_reg, wr_y_reg, wr_z_reg);
                ram_wdata  = kind_reg;
                state_next = ST_DONE;
            end
            ST_SETUP: begin
                ctl.mul_en = 1'b1;
                if (mul_grp_reg == MG_PLACE && mul_axis_reg == AXIS_LAST) begin
                    state_next = ST_MARCH;
                end
            end
            ST_MARCH: begin
                // The read issued last cycle is checked while the next one goes out.
                if (s1_ok_reg && rd_data != KIND_AIR) begin
                    hit_now    = 1'b1;
                    state_next = ST_BREAK;
                end else if (k_reg < max_steps_reg) begin
                    issue       = 1'b1;
                    ctl.advance = 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_BREAK: begin
                if (action_reg[ACT_BREAK]) begin
                    ram_we = 1'b1;
                end
                state_next = action_reg[ACT_PLACE] ? ST_PREAD : ST_DONE;
            end
            ST_PREAD: begin
                ram_raddr  = place_addr;
                state_next = place.in_grid ? ST_PCHECK : ST_DONE;
            end
            ST_PCHECK: begin
                if (rd_data == KIND_AIR) begin
                    ram_we    = 1'b1;
                    ram_waddr = place_addr;
                    ram_wdata = kind_reg;
                    place_ok  = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg   <= '0;
            k_reg         <= '0;
            mul_grp_reg   <= MG_START;
            mul_axis_reg  <= '0;
            s1_ok_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            step_reg      <= STEP_RESET;
            start_reg     <= START_RESET;
            max_steps_reg <= STEPS_RESET;
            poff_reg      <= POFF_RESET;
        end else begin
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_STEP_SIZE:      step_reg      <= cfg_wdata[STEP_W-1:0];
                    CFG_START_DISTANCE: start_reg     <= cfg_wdata[START_W-1:0];
                    CFG_MAX_STEPS:      max_steps_reg <= cfg_wdata[STEPS_W-1:0];
                    CFG_PLACE_OFFSET:   poff_reg      <= cfg_wdata[POFF_W-1:0];
                    default:            ;
                endcase
            end
            if (ctl.load) begin
                k_reg        <= '0;
                mul_grp_reg  <= MG_START;
                mul_axis_reg <= '0;
                s1_ok_reg    <= 1'b0;
            end
            if (ctl.mul_en) begin
                if (mul_axis_reg == AXIS_LAST) begin
                    mul_axis_reg <= '0;
                    case (mul_grp_reg)
                        MG_START: mul_grp_reg <= MG_STEP;
                        MG_STEP:  mul_grp_reg <= MG_PLACE;
                        default:  mul_grp_reg <= MG_START;
                    endcase
                end else begin
                    mul_axis_reg <= mul_axis_reg + 1'b1;
                end
            end
            if (issue) begin
                k_reg     <= k_reg + 1'b1;
                s1_ok_reg <= cur.in_grid;
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request payload, result and output registers.
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            wr_x_reg          <= s_cell_x;
            wr_y_reg          <= s_cell_y;
            wr_z_reg          <= s_cell_z;
            kind_reg          <= s_cell_type;
            action_reg        <= s_action;
            res_hit_reg       <= 1'b0;
            res_hit_pos_reg   <= '0;
            res_kind_reg      <= KIND_AIR;
            res_placed_reg    <= 1'b0;
            res_place_pos_reg <= '0;
        end
        if (hit_now) begin
            res_hit_reg     <= 1'b1;
            res_hit_pos_reg <= s1;
            res_kind_reg    <= rd_data;
        end
        if (place_ok) begin
            res_placed_reg    <= 1'b1;
            res_place_pos_reg <= place;
        end
        if (finish) begin
            m_hit_reg       <= res_hit_reg;
            m_hit_pos_reg   <= res_hit_pos_reg;
            m_kind_reg      <= res_kind_reg;
            m_placed_reg    <= res_placed_reg;
            m_place_pos_reg <= res_place_pos_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_hit      = m_hit_reg;
    assign m_hit_x    = m_hit_pos_reg.x;
    assign m_hit_y    = m_hit_pos_reg.y;
    assign m_hit_z    = m_hit_pos_reg.z;
    assign m_hit_kind = m_kind_reg;
    assign m_placed   = m_placed_reg;
    assign m_place_x  = m_place_pos_reg.x;
    assign m_place_y  = m_place_pos_reg.y;
    assign m_place_z  = m_place_pos_reg.z;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Testbench for voxel_ray_pick_edit_unit: cell writes and ray picks against a behavioral
// copy of the voxel grid, with every result field checked. Needs vrpe_pkg and the unit RTL.
module tb;
    import vrpe_pkg::*;

    localparam int     CLK_HALF    = 5;
    localparam longint CYCLE_LIMIT = 1500000;
    localparam int     TAIL_CYCLES = 40;

    localparam longint CELL    = longint'(1) << FRAC_BITS;
    localparam longint HALF    = CELL / 2;
    localparam longint ONE_DIR = longint'(1) << DIR_FRAC;

    localparam logic OP_PICK = 1'b1;

    localparam logic [ACTION_W-1:0] ACTION_NONE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACTION_BREAK = 2'd1;
    localparam logic [ACTION_W-1:0] ACTION_PLACE = 2'd2;
    localparam logic [ACTION_W-1:0] ACTION_BOTH  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_GRASS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STONE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_THREE = 2'd3;

    // Most random traffic lands in this cube so that picks find something.
    localparam int BOX_X = 12;
    localparam int BOX_Y = 28;
    localparam int BOX_Z = 12;
    localparam int BOX_N = 8;

    typedef struct packed {
        logic                    operation;
        logic [X_W-1:0]          cell_x;
        logic [Y_W-1:0]          cell_y;
        logic [Z_W-1:0]          cell_z;
        logic [KIND_W-1:0]       cell_type;
        logic [POS_W-1:0]        origin_x;
        logic [POS_W-1:0]        origin_y;
        logic [POS_W-1:0]        origin_z;
        logic [DIR_W-1:0]        dir_x;
        logic [DIR_W-1:0]        dir_y;
        logic [DIR_W-1:0]        dir_z;
        logic [ACTION_W-1:0]     action;
    } vox_req_t;

    typedef struct packed {
        logic                hit;
        logic [X_W-1:0]      hit_x;
        logic [Y_W-1:0]      hit_y;
        logic [Z_W-1:0]      hit_z;
        logic [KIND_W-1:0]   hit_kind;
        logic                placed;
        logic [X_W-1:0]      place_x;
        logic [Y_W-1:0]      place_y;
        logic [Z_W-1:0]      place_z;
    } pick_res_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_wdata = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_operation = 1'b0;
    logic [X_W-1:0]             s_cell_x = '0;
    logic [Y_W-1:0]             s_cell_y = '0;
    logic [Z_W-1:0]             s_cell_z = '0;
    logic [KIND_W-1:0]          s_cell_type = '0;
    logic signed [POS_W-1:0]    s_origin_x = '0;
    logic signed [POS_W-1:0]    s_origin_y = '0;
    logic signed [POS_W-1:0]    s_origin_z = '0;
    logic signed [DIR_W-1:0]    s_dir_x = '0;
    logic signed [DIR_W-1:0]    s_dir_y = '0;
    logic signed [DIR_W-1:0]    s_dir_z = '0;
    logic [ACTION_W-1:0]        s_action = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic                       m_hit;
    logic [X_W-1:0]             m_hit_x;
    logic [Y_W-1:0]             m_hit_y;
    logic [Z_W-1:0]             m_hit_z;
    logic [KIND_W-1:0]          m_hit_kind;
    logic                       m_placed;
    logic [X_W-1:0]             m_place_x;
    logic [Y_W-1:0]             m_place_y;
    logic [Z_W-1:0]             m_place_z;

    voxel_ray_pick_edit_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_cell_x    (s_cell_x),
        .s_cell_y    (s_cell_y),
        .s_cell_z    (s_cell_z),
        .s_cell_type (s_cell_type),
        .s_origin_x  (s_origin_x),
        .s_origin_y  (s_origin_y),
        .s_origin_z  (s_origin_z),
        .s_dir_x     (s_dir_x),
        .s_dir_y     (s_dir_y),
        .s_dir_z     (s_dir_z),
        .s_action    (s_action),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_hit_x     (m_hit_x),
        .m_hit_y     (m_hit_y),
        .m_hit_z     (m_hit_z),
        .m_hit_kind  (m_hit_kind),
        .m_placed    (m_placed),
        .m_place_x   (m_place_x),
        .m_place_y   (m_place_y),
        .m_place_z   (m_place_z)
    );

    // Shadow copy of the grid and the registers.
    logic [KIND_W-1:0] grid_mem [CELL_COUNT];
    longint            cur_step;
    longint            cur_start;
    longint            cur_steps;
    longint            cur_poff;

    pick_res_t  expected_results [$];

    bit         gaps_on = 1'b1;
    bit         stalls_on = 1'b1;
    int         hold_left = 0;
    int         stall_left = 0;
    longint     cycle_count = 0;
    int         n_errors = 0;
    int         n_writes = 0;
    int         n_picks = 0;
    int         n_results = 0;
    int         n_hits = 0;
    int         n_placed = 0;
    int         n_settings = 0;

    always #CLK_HALF aclk = ~aclk;

    function automatic bit in_bounds(longint x, longint y, longint z);
        return x >= 0 && x < longint'(GRID_X) && y >= 0 && y < longint'(GRID_Y)
            && z >= 0 && z < longint'(GRID_Z);
    endfunction

    function automatic int unsigned grid_index(longint x, longint y, longint z);
        return int'((x * GRID_Y + y) * GRID_Z + z);
    endfunction

    // Applies one request to the shadow grid and returns the result it must produce.
    function automatic pick_res_t apply_request(vox_req_t r);
        pick_res_t   res;
        longint      org [3];
        longint      dirv [3];
        longint      pt [3];
        longint      cel [3];
        longint      pc [3];
        longint      d;
        int unsigned a;
        int unsigned b;
        res = '0;
        if (r.operation == OP_WRITE) begin
            // The index widths match the grid, so every write lands.
            grid_mem[grid_index(r.cell_x, r.cell_y, r.cell_z)] = r.cell_type;
            return res;
        end
        org[0]  = longint'($signed(r.origin_x));
        org[1]  = longint'($signed(r.origin_y));
        org[2]  = longint'($signed(r.origin_z));
        dirv[0] = longint'($signed(r.dir_x));
        dirv[1] = longint'($signed(r.dir_y));
        dirv[2] = longint'($signed(r.dir_z));
        for (longint k = 0; k < cur_steps; k++) begin
            d = cur_start + k * cur_step;
            for (int i = 0; i < 3; i++) begin
                pt[i]  = org[i] + ((dirv[i] * d) >>> DIR_FRAC);
                cel[i] = pt[i] >>> FRAC_BITS;
            end
            if (!in_bounds(cel[0], cel[1], cel[2]))
                continue;
            a = grid_index(cel[0], cel[1], cel[2]);
            if (grid_mem[a] == KIND_AIR)
                continue;
            res.hit      = 1'b1;
            res.hit_x    = X_W'(cel[0]);
            res.hit_y    = Y_W'(cel[1]);
            res.hit_z    = Z_W'(cel[2]);
            res.hit_kind = grid_mem[a];
            if (r.action[ACT_BREAK])
                grid_mem[a] = KIND_AIR;
            if (r.action[ACT_PLACE]) begin
                for (int i = 0; i < 3; i++)
                    pc[i] = (pt[i] + ((dirv[i] * cur_poff) >>> DIR_FRAC)) >>> FRAC_BITS;
                if (in_bounds(pc[0], pc[1], pc[2])) begin
                    b = grid_index(pc[0], pc[1], pc[2]);
                    if (grid_mem[b] == KIND_AIR) begin
                        grid_mem[b]   = r.cell_type;
                        res.placed    = 1'b1;
                        res.place_x   = X_W'(pc[0]);
                        res.place_y   = Y_W'(pc[1]);
                        res.place_z   = Z_W'(pc[2]);
                    end
                end
            end
            break;
        end
        return res;
    endfunction

    function automatic vox_req_t rand_req();
        vox_req_t r;
        r.operation = $urandom;
        r.cell_x    = $urandom;
        r.cell_y    = $urandom;
        r.cell_z    = $urandom;
        r.cell_type = $urandom;
        r.origin_x  = $urandom;
        r.origin_y  = $urandom;
        r.origin_z  = $urandom;
        r.dir_x     = $urandom;
        r.dir_y     = $urandom;
        r.dir_z     = $urandom;
        r.action    = $urandom;
        return r;
    endfunction

    function automatic vox_req_t make_write(int x, int y, int z, logic [KIND_W-1:0] kind);
        vox_req_t r;
        r = rand_req();
        r.operation = OP_WRITE;
        r.cell_x    = X_W'(x);
        r.cell_y    = Y_W'(y);
        r.cell_z    = Z_W'(z);
        r.cell_type = kind;
        return r;
    endfunction

    function automatic vox_req_t make_pick(longint ox, longint oy, longint oz,
                                           longint dx, longint dy, longint dz,
                                           logic [ACTION_W-1:0] act,
                                           logic [KIND_W-1:0] kind);
        vox_req_t r;
        r = rand_req();
        r.operation = OP_PICK;
        r.origin_x  = POS_W'(ox);
        r.origin_y  = POS_W'(oy);
        r.origin_z  = POS_W'(oz);
        r.dir_x     = DIR_W'(dx);
        r.dir_y     = DIR_W'(dy);
        r.dir_z     = DIR_W'(dz);
        r.action    = act;
        r.cell_type = kind;
        return r;
    endfunction

    // A pick that starts a few cells away from a cube cell and points straight at it.
    function automatic vox_req_t aimed_pick();
        vox_req_t r;
        longint   off [3];
        longint   tgt [3];
        longint   m;
        tgt[0] = BOX_X + $urandom_range(0, BOX_N - 1);
        tgt[1] = BOX_Y + $urandom_range(0, BOX_N - 1);
        tgt[2] = BOX_Z + $urandom_range(0, BOX_N - 1);
        m = 0;
        for (int i = 0; i < 3; i++) begin
            off[i] = longint'($urandom_range(0, 8 * 4096)) - 4 * CELL;
            if (off[i] > m)
                m = off[i];
            if (-off[i] > m)
                m = -off[i];
        end
        if (m == 0) begin
            off[0] = CELL;
            m = CELL;
        end
        r = make_pick(tgt[0] * CELL + HALF + off[0], tgt[1] * CELL + HALF + off[1],
                      tgt[2] * CELL + HALF + off[2], -off[0] * ONE_DIR / m,
                      -off[1] * ONE_DIR / m, -off[2] * ONE_DIR / m, $urandom, $urandom);
        return r;
    endfunction

    function automatic vox_req_t next_random_req();
        vox_req_t r;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            r = make_write(BOX_X + $urandom_range(0, BOX_N - 1), BOX_Y + $urandom_range(0, BOX_N - 1),
                           BOX_Z + $urandom_range(0, BOX_N - 1),
                           ($urandom_range(0, 4) == 0) ? KIND_AIR : KIND_W'($urandom_range(1, 3)));
        end else if (roll < 38) begin
            r = rand_req();
            r.operation = OP_WRITE;
        end else if (roll < 88) begin
            r = aimed_pick();
        end else begin
            r = rand_req();
            r.operation = OP_PICK;
            // Half of the stray picks start somewhere inside the grid.
            if ($urandom_range(0, 1) == 0) begin
                r.origin_x = POS_W'($urandom_range(0, GRID_X * 4096 - 1));
                r.origin_y = POS_W'($urandom_range(0, GRID_Y * 4096 - 1));
                r.origin_z = POS_W'($urandom_range(0, GRID_Z * 4096 - 1));
            end
        end
        return r;
    endfunction

    // Offers one request, holds it until accepted, and records its expected result.
    task automatic send_req(vox_req_t r);
        s_valid     <= 1'b1;
        s_operation <= r.operation;
        s_cell_x    <= r.cell_x;
        s_cell_y    <= r.cell_y;
        s_cell_z    <= r.cell_z;
        s_cell_type <= r.cell_type;
        s_origin_x  <= r.origin_x;
        s_origin_y  <= r.origin_y;
        s_origin_z  <= r.origin_z;
        s_dir_x     <= r.dir_x;
        s_dir_y     <= r.dir_y;
        s_dir_z     <= r.dir_z;
        s_action    <= r.action;
        do @(posedge aclk); while (s_ready !== 1'b1);
        expected_results.push_back(apply_request(r));
        if (r.operation == OP_WRITE)
            n_writes++;
        else
            n_picks++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    // Leaves the write enable high; set_config lowers it after the last register.
    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            CFG_STEP_SIZE:      cur_step  = longint'(value[STEP_W-1:0]);
            CFG_START_DISTANCE: cur_start = longint'(value[START_W-1:0]);
            CFG_MAX_STEPS:      cur_steps = longint'(value[STEPS_W-1:0]);
            CFG_PLACE_OFFSET:   cur_poff  = longint'(value[POFF_W-1:0]);
            default: ;
        endcase
    endtask

    // Unused upper bits of the narrower registers carry random junk.
    task automatic set_config(int unsigned step_v, int unsigned start_v,
                              int unsigned steps_v, int unsigned poff_v);
        write_reg(CFG_STEP_SIZE, (CFG_W'($urandom) << STEP_W) | CFG_W'(step_v));
        write_reg(CFG_START_DISTANCE, CFG_W'(start_v));
        write_reg(CFG_MAX_STEPS, (CFG_W'($urandom) << STEPS_W) | CFG_W'(steps_v));
        write_reg(CFG_PLACE_OFFSET, (CFG_W'($urandom) << POFF_W) | CFG_W'(poff_v));
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    task automatic test_empty_grid();
        send_req(make_pick(16 * CELL + HALF, 32 * CELL + HALF, 16 * CELL + HALF,
                           ONE_DIR, 0, 0, ACTION_BOTH, KIND_STONE));
    endtask

    task automatic test_directed_hits();
        send_req(make_write(0, 0, 0, KIND_GRASS));
        send_req(make_write(GRID_X - 1, GRID_Y - 1, GRID_Z - 1, KIND_STONE));
        send_req(make_write(10, 20, 10, KIND_THREE));
        send_req(make_pick(10 * CELL + HALF, 18 * CELL + HALF, 10 * CELL + HALF,
                           0, ONE_DIR, 0, ACTION_NONE, KIND_GRASS));
        // The placement point stays in the hit cell, so a break lets it be filled.
        send_req(make_pick(10 * CELL + HALF, 18 * CELL + HALF, 10 * CELL + HALF,
                           0, ONE_DIR, 0, ACTION_BOTH, KIND_STONE));
        send_req(make_pick(10 * CELL + HALF, 18 * CELL + HALF, 10 * CELL + HALF,
                           0, ONE_DIR, 0, ACTION_BOTH, KIND_AIR));
        send_req(make_pick(HALF, 3 * CELL + HALF, HALF, 0, -ONE_DIR, 0, ACTION_NONE, KIND_AIR));
        send_req(make_pick(HALF, -CELL, HALF, 0, ONE_DIR, 0, ACTION_BREAK, KIND_AIR));
        send_req(make_write(0, 0, 0, KIND_GRASS));
        send_req(make_pick(31 * CELL + HALF, 58 * CELL + HALF, 31 * CELL + HALF,
                           0, ONE_DIR, 0, ACTION_PLACE, KIND_GRASS));
        send_req(make_pick(-1048576, -1048576, -1048576, -ONE_DIR, -ONE_DIR, -ONE_DIR,
                           ACTION_BOTH, KIND_GRASS));
        send_req(make_pick(1048575, 1048575, 1048575, 32767, -32768, 32767,
                           ACTION_BOTH, KIND_THREE));
    endtask

    task automatic test_config_extremes();
        wait_idle();
        set_config(205, 410, 0, 410);
        send_req(make_pick(HALF, -CELL, HALF, 0, ONE_DIR, 0, ACTION_BOTH, KIND_STONE));
        wait_idle();
        set_config(205, 0, 1, 0);
        send_req(make_pick(HALF, HALF, HALF, ONE_DIR, 0, 0, ACTION_PLACE, KIND_STONE));
        send_req(make_pick(HALF, HALF, HALF, ONE_DIR, 0, 0, ACTION_BOTH, KIND_STONE));
        wait_idle();
        set_config(4095, 0, 20, 4095);
        send_req(make_write(5, 62, 5, KIND_GRASS));
        send_req(make_pick(5 * CELL + HALF, 60 * CELL + HALF, 5 * CELL + HALF,
                           0, ONE_DIR, 0, ACTION_PLACE, KIND_GRASS));
        // Here the placement point falls past the top face of the grid.
        send_req(make_write(7, 63, 7, KIND_STONE));
        send_req(make_pick(7 * CELL + HALF, 61 * CELL + HALF, 7 * CELL + HALF,
                           0, ONE_DIR, 0, ACTION_PLACE, KIND_GRASS));
        wait_idle();
        set_config(1, 65535, 1023, 4095);
        send_req(make_pick(HALF, -16 * CELL + HALF, HALF, 0, ONE_DIR, 0, ACTION_NONE, KIND_AIR));
        wait_idle();
        set_config(4095, 65535, 1023, 0);
        send_req(make_pick(31 * CELL + HALF, -1048576, 31 * CELL + HALF,
                           0, ONE_DIR, 0, ACTION_BOTH, KIND_THREE));
    endtask

    task automatic run_random_phase(int n, int unsigned step_v, int unsigned start_v,
                                    int unsigned steps_v, int unsigned poff_v, bit idle);
        wait_idle();
        set_config(step_v, start_v, steps_v, poff_v);
        gaps_on   = idle;
        stalls_on = idle;
        for (int i = 0; i < n; i++) begin
            send_req(next_random_req());
            if (idle && $urandom_range(0, 99) == 0)
                wait_idle();
        end
    endtask

    // The output side holds off long enough for the unit to fill and stall its input.
    task automatic test_backpressure();
        wait_idle();
        set_config(205, 410, 118, 410);
        hold_left = 3000;
        for (int i = 0; i < 20; i++)
            send_req(aimed_pick());
        wait_idle();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 4; p++)
            run_random_phase(50, $urandom_range(1, 600), $urandom_range(0, 8192),
                             $urandom_range(1, 150), $urandom_range(0, 4095), 1'b1);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge aclk) begin
        pick_res_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            n_results++;
            if (m_hit === 1'b1)
                n_hits++;
            if (m_placed === 1'b1)
                n_placed++;
            if (expected_results.size() == 0) begin
                $error("result arrived with no request outstanding");
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("hit", want.hit, m_hit);
                check_field("hit_x", want.hit_x, m_hit_x);
                check_field("hit_y", want.hit_y, m_hit_y);
                check_field("hit_z", want.hit_z, m_hit_z);
                check_field("hit_kind", want.hit_kind, m_hit_kind);
                check_field("placed", want.placed, m_placed);
                check_field("place_x", want.place_x, m_place_x);
                check_field("place_y", want.place_y, m_place_y);
                check_field("place_z", want.place_z, m_place_z);
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(1, 9) - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        foreach (grid_mem[i])
            grid_mem[i] = KIND_AIR;
        cur_step  = longint'(STEP_RESET);
        cur_start = longint'(START_RESET);
        cur_steps = longint'(STEPS_RESET);
        cur_poff  = longint'(POFF_RESET);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_grid();
        test_directed_hits();
        test_config_extremes();
        run_random_phase(350, 205, 410, 118, 410, 1'b1);
        test_backpressure();
        run_random_phase(250, 205, 0, 40, 4095, 1'b1);
        run_random_phase(25, 4095, 65535, 1023, 4095, 1'b1);
        run_random_phase(25, 1, 0, 1023, 0, 1'b1);
        test_random_settings();
        run_random_phase(200, 300, 100, 100, 2000, 1'b0);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            n_errors++;
        end
        $display("Covered %0d writes and %0d picks over %0d register settings.",
                 n_writes, n_picks, n_settings);
        $display("Checked %0d results: %0d hits, %0d placements, %0d mismatches.",
                 n_results, n_hits, n_placed, n_errors);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
